// ===== sv/mvd_pkg.sv =====
// Shared types, codes and constants of the vector distance core.
// No dependencies; every other file imports this package.
package mvd_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int MAX_LEN_DEF = 4096;
  localparam int MODE_W      = 4;
  localparam int ACC_W       = 48;

  // fixed-point shift amounts that follow from the element format
  localparam int HEL_SH = 32 - FRAC_BITS;
  localparam int EUC_SH = 32 - 2 * FRAC_BITS;
  localparam int Q16_SH = 16 - FRAC_BITS;

  localparam logic [15:0]      ELEM_ONE = 16'(1 << FRAC_BITS);
  localparam logic [ACC_W-1:0] ONE_Q16  = ACC_W'(65536);

  // divider: 17 quotient bits, quotient never needs more except for the clamp
  localparam int DIV_Q_W = 17;
  localparam int DIV_D_W = 48;
  localparam int DIV_N_W = DIV_D_W + DIV_Q_W - 1;

  // square root: 56-bit radicand, 28-bit root
  localparam int SQ_W   = 56;
  localparam int SQ_R_W = SQ_W / 2;

  localparam logic [MODE_W-1:0] MODE_MAN = 4'd0;
  localparam logic [MODE_W-1:0] MODE_EUC = 4'd1;
  localparam logic [MODE_W-1:0] MODE_CHE = 4'd2;
  localparam logic [MODE_W-1:0] MODE_CAN = 4'd3;
  localparam logic [MODE_W-1:0] MODE_RR  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_COS = 4'd5;
  localparam logic [MODE_W-1:0] MODE_JAC = 4'd6;
  localparam logic [MODE_W-1:0] MODE_HEL = 4'd7;
  localparam logic [MODE_W-1:0] MODE_HAM = 4'd8;

  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_AD   = 3'd1;
  localparam logic [2:0] MUL_XY   = 3'd2;
  localparam logic [2:0] MUL_XX   = 3'd3;
  localparam logic [2:0] MUL_YY   = 3'd4;
  localparam logic [2:0] MUL_DD   = 3'd5;
  localparam logic [2:0] MUL_SXSY = 3'd6;

  localparam logic [2:0] ADD_NONE = 3'd0;
  localparam logic [2:0] ADD_ACC  = 3'd1;
  localparam logic [2:0] ADD_DOT  = 3'd2;
  localparam logic [2:0] ADD_XE   = 3'd3;
  localparam logic [2:0] ADD_YE   = 3'd4;

  localparam logic [2:0] SQ_X   = 3'd0;
  localparam logic [2:0] SQ_Y   = 3'd1;
  localparam logic [2:0] SQ_EUC = 3'd2;
  localparam logic [2:0] SQ_XE  = 3'd3;
  localparam logic [2:0] SQ_YE  = 3'd4;
  localparam logic [2:0] SQ_HEL = 3'd5;

  localparam logic [1:0] DIV_CANB = 2'd0;
  localparam logic [1:0] DIV_RR   = 2'd1;
  localparam logic [1:0] DIV_JAC  = 2'd2;
  localparam logic [1:0] DIV_COS  = 2'd3;

  typedef struct packed {
    logic signed [15:0] x_elem;
    logic signed [15:0] y_elem;
    logic               last_pair;
  } pair_t;

  typedef struct packed {
    logic [47:0] distance_value;
    logic        math_error;
  } dist_t;

  typedef struct packed {
    logic       capture;
    logic       simple;
    logic [2:0] mul_sel;
    logic [2:0] add_sel;
    logic       sq_start;
    logic [2:0] sq_src;
    logic       sq_cap_a;
    logic       sq_cap_b;
    logic       div_start;
    logic [1:0] div_src;
    logic       div_add;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              last;
    logic              den_zero;
    logic              xe_zero;
    logic              prod_zero;
    logic              div_busy;
    logic              sq_busy;
    logic              out_free;
  } sts_t;

endpackage

// ===== sv/mvd_div.sv =====
// Restoring divider, one quotient bit per cycle, with overflow detect.
// Depends on mvd_pkg.
module mvd_div import mvd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output logic               busy,
  output logic [DIV_Q_W-1:0] quot,
  output logic               ovf
);

  localparam int CW = $clog2(DIV_Q_W);

  logic [DIV_N_W-1:0] rem;
  logic [DIV_N_W-1:0] dsh;
  logic [CW-1:0]      cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DIV_Q_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= {den, {(DIV_Q_W-1){1'b0}}};
      ovf  <= {1'b0, num} >= {den, {DIV_Q_W{1'b0}}};
      quot <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[DIV_Q_W-2:0], 1'b1};
      end else begin
        quot <= {quot[DIV_Q_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

endmodule

// ===== sv/mvd_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle (floor).
// Depends on mvd_pkg.
module mvd_sqrt import mvd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   arg,
  output logic              busy,
  output logic [SQ_R_W-1:0] root
);

  localparam int CW = $clog2(SQ_R_W);

  logic [SQ_W-1:0]     a;
  logic [SQ_R_W+1:0]   rem;
  logic [SQ_R_W+1:0]   remn;
  logic [SQ_R_W+1:0]   trial;
  logic [CW-1:0]       cnt;

  assign remn  = {rem[SQ_R_W-1:0], a[SQ_W-1:SQ_W-2]};
  assign trial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(SQ_R_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a    <= arg;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      a <= a << 2;
      if (remn >= trial) begin
        rem  <= remn - trial;
        root <= {root[SQ_R_W-2:0], 1'b1};
      end else begin
        rem  <= remn;
        root <= {root[SQ_R_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== sv/mvd_datapath.sv =====
// Datapath: mode register, accumulators, multiplier, shared divider and
// square root, finishing formulas and output register. Depends on mvd_pkg.
module mvd_datapath import mvd_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [MODE_W-1:0] cfg_wdata,
  input  pair_t             pair,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              dist_valid,
  input  logic              dist_stall,
  output dist_t             result
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

  logic [MODE_W-1:0]  mode;
  logic signed [15:0] xr, yr;
  logic               lastr;
  logic [ACC_W-1:0]   acc, xe, ye;
  logic signed [47:0] dot;
  logic [CNT_W-1:0]   cnt;
  logic               err;
  logic signed [49:0] prod;
  logic [SQ_R_W-1:0]  ra, rb;

  logic signed [16:0] d17;
  logic [15:0]        ad, ax, ay;
  logic [16:0]        den17;
  logic               xone, yone;
  logic signed [24:0] ma, mb;
  logic [SQ_R_W-1:0]  dd;
  logic signed [49:0] dsum;
  logic [47:0]        mag;

  logic               sq_busy;
  logic [SQ_R_W-1:0]  sq_root;
  logic [SQ_W-1:0]    sq_arg;
  logic               div_busy, div_ovf;
  logic [DIV_Q_W-1:0] quot, qc;
  logic [DIV_N_W-1:0] div_num;
  logic [DIV_D_W-1:0] div_den;
  logic [ACC_W-1:0]   nn, bb, ii;
  logic [ACC_W-1:0]   fin_val;
  logic               fin_err;
  logic               out_free;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? '1 : s[ACC_W-1:0];
  endfunction

  assign d17   = {xr[15], xr} - {yr[15], yr};
  assign ad    = d17[16] ? 16'(-d17) : d17[15:0];
  assign ax    = xr[15] ? 16'(-xr) : 16'(xr);
  assign ay    = yr[15] ? 16'(-yr) : 16'(yr);
  assign den17 = {1'b0, ax} + {1'b0, ay};
  assign xone  = xr == ELEM_ONE;
  assign yone  = yr == ELEM_ONE;
  assign dd    = (ra >= rb) ? ra - rb : rb - ra;
  assign dsum  = 50'(dot) + prod;
  assign mag   = dot[47] ? 48'(-dot) : 48'(dot);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_sel)
      MUL_AD:   begin ma = {9'b0, ad}; mb = {9'b0, ad}; end
      MUL_XY:   begin ma = 25'(xr); mb = 25'(yr); end
      MUL_XX:   begin ma = 25'(xr); mb = 25'(xr); end
      MUL_YY:   begin ma = 25'(yr); mb = 25'(yr); end
      MUL_DD:   begin ma = {1'b0, dd[23:0]}; mb = {1'b0, dd[23:0]}; end
      MUL_SXSY: begin ma = {1'b0, ra[23:0]}; mb = {1'b0, rb[23:0]}; end
      default:  begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    case (cmd.sq_src)
      SQ_X:    sq_arg = (!xr[15] && xr != '0) ? SQ_W'(xr[14:0]) << HEL_SH : '0;
      SQ_Y:    sq_arg = (!yr[15] && yr != '0) ? SQ_W'(yr[14:0]) << HEL_SH : '0;
      SQ_EUC:  sq_arg = SQ_W'(acc) << EUC_SH;
      SQ_XE:   sq_arg = SQ_W'(xe);
      SQ_YE:   sq_arg = SQ_W'(ye);
      SQ_HEL:  sq_arg = SQ_W'(acc >> 1);
      default: sq_arg = '0;
    endcase
  end

  // operands of the shared divider; quotient is always a Q.16 fraction
  assign nn = ACC_W'(cnt);
  assign bb = (acc > nn) ? nn : acc;
  assign ii = (ye > xe) ? xe : ye;

  always_comb begin
    case (cmd.div_src)
      DIV_CANB: begin div_num = DIV_N_W'({ad, 16'b0}); div_den = DIV_D_W'(den17); end
      DIV_RR:   begin div_num = {nn - bb, 16'b0}; div_den = nn; end
      DIV_JAC:  begin div_num = {xe - ii, 16'b0}; div_den = xe; end
      default:  begin div_num = {mag, 16'b0}; div_den = prod[47:0]; end
    endcase
  end

  mvd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sq_start),
    .arg   (sq_arg),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  mvd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot),
    .ovf   (div_ovf)
  );

  assign qc = (div_ovf || quot > DIV_Q_W'(65536)) ? DIV_Q_W'(65536) : quot;

  always_comb begin
    fin_val = '0;
    unique case (mode) inside
      MODE_MAN, MODE_CHE: fin_val = ((acc >> (ACC_W - Q16_SH)) != '0) ? '1 : acc << Q16_SH;
      MODE_EUC:           fin_val = ACC_W'(ra);
      MODE_CAN:           fin_val = acc;
      MODE_RR:            fin_val = ACC_W'(quot);
      MODE_COS: begin
        if (prod == '0) begin
          fin_val = '0;
        end else begin
          fin_val = dot[47] ? ONE_Q16 + ACC_W'(qc) : ONE_Q16 - ACC_W'(qc);
        end
      end
      MODE_JAC:           fin_val = (xe == '0) ? '0 : ACC_W'(quot);
      MODE_HEL:           fin_val = ACC_W'(ra);
      MODE_HAM:           fin_val = acc << 16;
      default:            fin_val = '0;
    endcase
  end

  assign fin_err  = (mode <= MODE_HAM) && (err || (mode == MODE_COS && prod == '0));
  assign out_free = !dist_valid || !dist_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_EUC;
    end else if (cfg_wen) begin
      mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xr    <= pair.x_elem;
      yr    <= pair.y_elem;
      lastr <= pair.last_pair;
    end
    if (cmd.mul_sel != MUL_NONE) begin
      prod <= ma * mb;
    end
    if (cmd.sq_cap_a) begin
      ra <= sq_root;
    end
    if (cmd.sq_cap_b) begin
      rb <= sq_root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.fin) begin
      acc <= '0;
      xe  <= '0;
      ye  <= '0;
      dot <= '0;
      cnt <= '0;
      err <= 1'b0;
    end else begin
      if (cmd.capture && cnt < CNT_MAX) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.simple) begin
        unique case (mode)
          MODE_MAN: acc <= sat_add(acc, ACC_W'(ad));
          MODE_CHE: if (ACC_W'(ad) > acc) acc <= ACC_W'(ad);
          MODE_RR:  if (xone && yone) acc <= sat_add(acc, ACC_W'(1));
          MODE_JAC: begin
            if (xone || yone) xe <= sat_add(xe, ACC_W'(1));
            if (xone && yone) ye <= sat_add(ye, ACC_W'(1));
          end
          MODE_HEL: if (xr[15] || yr[15]) err <= 1'b1;
          MODE_HAM: if (xr != yr) acc <= sat_add(acc, ACC_W'(1));
          default:  ;
        endcase
      end
      case (cmd.add_sel)
        ADD_ACC: acc <= sat_add(acc, prod[47:0]);
        ADD_DOT: begin
          // clamp to the signed 48-bit range
          if (!dsum[49] && dsum[48:47] != 2'b00) begin
            dot <= {1'b0, {47{1'b1}}};
          end else if (dsum[49] && dsum[48:47] != 2'b11) begin
            dot <= {1'b1, {47{1'b0}}};
          end else begin
            dot <= dsum[47:0];
          end
        end
        ADD_XE:  xe <= sat_add(xe, prod[47:0]);
        ADD_YE:  ye <= sat_add(ye, prod[47:0]);
        default: ;
      endcase
      if (cmd.div_add) begin
        acc <= sat_add(acc, ACC_W'(quot));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else if (cmd.fin) begin
      dist_valid <= 1'b1;
    end else if (!dist_stall) begin
      dist_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      result.distance_value <= fin_val;
      result.math_error     <= fin_err;
    end
  end

  assign sts.mode      = mode;
  assign sts.last      = lastr;
  assign sts.den_zero  = den17 == '0;
  assign sts.xe_zero   = xe == '0;
  assign sts.prod_zero = prod == '0;
  assign sts.div_busy  = div_busy;
  assign sts.sq_busy   = sq_busy;
  assign sts.out_free  = out_free;

  a_units_excl: assert property (@(posedge clk) disable iff (rst)
    !(div_busy && sq_busy))
    else $error("divider and square root busy together");

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> out_free)
    else $error("result loaded over an untaken beat");

  a_fin_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> (acc == '0 && cnt == '0 && !err && dist_valid))
    else $error("accumulators not cleared after result");

endmodule

// ===== sv/mvd_ctrl.sv =====
// Sequencer: walks each pair through the datapath and runs the final formula.
// Depends on mvd_pkg; talks to mvd_datapath through cmd_t and sts_t.
module mvd_ctrl import mvd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic pair_valid,
  output logic pair_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_ADDP = 5'd2;
  localparam logic [4:0] S_CWT  = 5'd3;
  localparam logic [4:0] S_COS1 = 5'd4;
  localparam logic [4:0] S_COS2 = 5'd5;
  localparam logic [4:0] S_COS3 = 5'd6;
  localparam logic [4:0] S_HWX  = 5'd7;
  localparam logic [4:0] S_HWY  = 5'd8;
  localparam logic [4:0] S_HMUL = 5'd9;
  localparam logic [4:0] S_POST = 5'd10;
  localparam logic [4:0] S_FSQ  = 5'd11;
  localparam logic [4:0] S_FCX  = 5'd12;
  localparam logic [4:0] S_FCY  = 5'd13;
  localparam logic [4:0] S_FCM  = 5'd14;
  localparam logic [4:0] S_FCP  = 5'd15;
  localparam logic [4:0] S_FDIV = 5'd16;
  localparam logic [4:0] S_FIN  = 5'd17;

  logic [4:0] state, state_next;

  assign pair_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pair_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.mode)
          MODE_EUC: begin
            cmd.mul_sel = MUL_AD;
            state_next  = S_ADDP;
          end
          MODE_CAN: begin
            if (sts.den_zero) begin
              state_next = S_POST;
            end else begin
              cmd.div_start = 1'b1;
              cmd.div_src   = DIV_CANB;
              state_next    = S_CWT;
            end
          end
          MODE_COS: begin
            cmd.mul_sel = MUL_XY;
            state_next  = S_COS1;
          end
          MODE_HEL: begin
            cmd.simple   = 1'b1;
            cmd.sq_start = 1'b1;
            cmd.sq_src   = SQ_X;
            state_next   = S_HWX;
          end
          default: begin
            cmd.simple = 1'b1;
            state_next = S_POST;
          end
        endcase
      end
      S_ADDP: begin
        cmd.add_sel = ADD_ACC;
        state_next  = S_POST;
      end
      S_CWT: begin
        if (!sts.div_busy) begin
          cmd.div_add = 1'b1;
          state_next  = S_POST;
        end
      end
      S_COS1: begin
        cmd.add_sel = ADD_DOT;
        cmd.mul_sel = MUL_XX;
        state_next  = S_COS2;
      end
      S_COS2: begin
        cmd.add_sel = ADD_XE;
        cmd.mul_sel = MUL_YY;
        state_next  = S_COS3;
      end
      S_COS3: begin
        cmd.add_sel = ADD_YE;
        state_next  = S_POST;
      end
      S_HWX: begin
        if (!sts.sq_busy) begin
          cmd.sq_cap_a = 1'b1;
          cmd.sq_start = 1'b1;
          cmd.sq_src   = SQ_Y;
          state_next   = S_HWY;
        end
      end
      S_HWY: begin
        if (!sts.sq_busy) begin
          cmd.sq_cap_b = 1'b1;
          state_next   = S_HMUL;
        end
      end
      S_HMUL: begin
        cmd.mul_sel = MUL_DD;
        state_next  = S_ADDP;
      end
      S_POST: begin
        if (!sts.last) begin
          state_next = S_IDLE;
        end else begin
          unique case (sts.mode) inside
            MODE_EUC, MODE_HEL: begin
              cmd.sq_start = 1'b1;
              cmd.sq_src   = (sts.mode == MODE_EUC) ? SQ_EUC : SQ_HEL;
              state_next   = S_FSQ;
            end
            MODE_RR: begin
              cmd.div_start = 1'b1;
              cmd.div_src   = DIV_RR;
              state_next    = S_FDIV;
            end
            MODE_JAC: begin
              if (sts.xe_zero) begin
                state_next = S_FIN;
              end else begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DIV_JAC;
                state_next    = S_FDIV;
              end
            end
            MODE_COS: begin
              cmd.sq_start = 1'b1;
              cmd.sq_src   = SQ_XE;
              state_next   = S_FCX;
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_FSQ: begin
        if (!sts.sq_busy) begin
          cmd.sq_cap_a = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_FCX: begin
        if (!sts.sq_busy) begin
          cmd.sq_cap_a = 1'b1;
          cmd.sq_start = 1'b1;
          cmd.sq_src   = SQ_YE;
          state_next   = S_FCY;
        end
      end
      S_FCY: begin
        if (!sts.sq_busy) begin
          cmd.sq_cap_b = 1'b1;
          state_next   = S_FCM;
        end
      end
      S_FCM: begin
        cmd.mul_sel = MUL_SXSY;
        state_next  = S_FCP;
      end
      S_FCP: begin
        if (sts.prod_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DIV_COS;
          state_next    = S_FDIV;
        end
      end
      S_FDIV: begin
        if (!sts.div_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/multi_metric_vector_distance_core.sv =====
// Top level of the multi-metric vector distance core: sequencer plus datapath.
// Depends on mvd_pkg, mvd_ctrl, mvd_datapath (which holds mvd_div, mvd_sqrt).
//
//  channel  | direction | handshake               | beat
//  ---------+-----------+-------------------------+-----------------------------
//  pair     | in        | pair_valid / pair_stall | x_elem, y_elem (Q4.12), last_pair
//  result   | out       | dist_valid / dist_stall | distance_value (Q32.16), math_error
//  cfg      | in        | cfg_wen                 | cfg_wdata = metric_mode
//
// Per beat: manhattan, chebyshev, russell-rao, jaccard, hamming update directly;
// euclidean adds a multiply-accumulate, cosine three, canberra a divide (none
// on a zero denominator), hellinger two roots and a multiply-accumulate. The
// last beat then loads the result, after any root and divide its metric needs.
// Sync reset: metric_mode = 1 (euclidean), accumulators cleared, result empty.
// pair_stall is high while a beat is in work; one finished beat waits in the
// result register, and the block stalls at the end of a vector only if it is
// still untaken.
module multi_metric_vector_distance_core import mvd_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [MODE_W-1:0] cfg_wdata,
  input  logic              pair_valid,
  output logic              pair_stall,
  input  pair_t             pair,
  output logic              dist_valid,
  input  logic              dist_stall,
  output dist_t             result
);

  cmd_t cmd;
  sts_t sts;

  // control walks one beat at a time through mul / divide / root steps
  mvd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath owns the mode register, accumulators and the result register
  mvd_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .pair       (pair),
    .cmd        (cmd),
    .sts        (sts),
    .dist_valid (dist_valid),
    .dist_stall (dist_stall),
    .result     (result)
  );

endmodule
